[src/qpr_pkg.sv]
// shared types, widths and term tables for the quaternion product and rotate unit
package qpr_pkg;

    localparam int WORD_BITS  = 16;
    localparam int FRAC_BITS  = 14;
    localparam int OP_BITS    = WORD_BITS + 1;
    localparam int PROD_BITS  = 2 * OP_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;

    localparam logic CMD_PRODUCT = 1'b0;
    localparam logic CMD_ROTATE  = 1'b1;

    // component positions
    localparam int CX = 0;
    localparam int CY = 1;
    localparam int CZ = 2;
    localparam int CW = 3;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX  = SUM_BITS'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic signed [SUM_BITS-1:0] SUM_MIN  = ~SUM_MAX;
    localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(64'd1 << (FRAC_BITS - 1));

    typedef logic [WORD_BITS-1:0]         word_t;
    typedef logic [3:0][WORD_BITS-1:0]    quat_t;
    typedef logic [3:0][OP_BITS-1:0]      quat_op_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

    // travels alongside the arithmetic through a multiply unit
    typedef struct packed {
        logic       cmd;
        quat_t      a;
        quat_t      prod;
        logic [3:0] sat;
    } side_t;

    // hamilton product: component c is the sum over t of +/- a[TERM_A] * b[TERM_B]
    localparam int TERM_A [4][4] = '{
        '{3, 0, 1, 2},
        '{3, 1, 2, 0},
        '{3, 2, 0, 1},
        '{3, 0, 1, 2}
    };
    localparam int TERM_B [4][4] = '{
        '{0, 3, 2, 1},
        '{1, 3, 0, 2},
        '{2, 3, 1, 0},
        '{3, 0, 1, 2}
    };
    localparam logic [3:0] TERM_NEG [4] = '{4'b1000, 4'b1000, 4'b1000, 4'b1110};

endpackage

[src/qpr_if.sv]
// valid/ready channel interfaces for the quaternion unit

interface qpr_in_if;
    import qpr_pkg::*;
    logic  valid;
    logic  ready;
    logic  command;
    word_t a_x;
    word_t a_y;
    word_t a_z;
    word_t a_w;
    word_t b_x;
    word_t b_y;
    word_t b_z;
    word_t b_w;

    modport source (output valid, command, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                    input ready);
    modport sink (input valid, command, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  output ready);
endinterface

interface qpr_out_if;
    import qpr_pkg::*;
    logic  valid;
    logic  ready;
    word_t r_x;
    word_t r_y;
    word_t r_z;
    word_t r_w;
    logic  saturated;

    modport source (output valid, r_x, r_y, r_z, r_w, saturated, input ready);
    modport sink (input valid, r_x, r_y, r_z, r_w, saturated, output ready);
endinterface

[src/qpr_qmul.sv]
// three-stage pipelined fixed-point hamilton product with round and saturate
module qpr_qmul
    import qpr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  quat_op_t a,
    input  quat_op_t b,
    input  side_t    in_side,
    output logic     out_valid,
    input  logic     out_ready,
    output quat_t    r,
    output logic [3:0] sat,
    output side_t    out_side
);

    logic [2:0] v_reg;
    logic [2:0] v_next;
    logic [2:0] rdy;

    prod_t p_reg  [4][4];
    prod_t p_next [4][4];
    sum_t  s_reg  [4];
    sum_t  s_next [4];
    quat_t      r_reg;
    quat_t      r_next;
    logic [3:0] sat_reg;
    logic [3:0] sat_next;
    side_t side1_reg;
    side_t side2_reg;
    side_t side3_reg;

    // a stage may load when it is empty or its content moves on
    assign rdy[2]   = !v_reg[2] || out_ready;
    assign rdy[1]   = !v_reg[1] || rdy[2];
    assign rdy[0]   = !v_reg[0] || rdy[1];
    assign in_ready = rdy[0];

    always_comb
    begin
        v_next = v_reg;
        if (rdy[0])
        begin
            v_next[0] = in_valid;
        end
        if (rdy[1])
        begin
            v_next[1] = v_reg[0];
        end
        if (rdy[2])
        begin
            v_next[2] = v_reg[1];
        end
    end

    // stage 1: sixteen products
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int t = 0; t < 4; t++)
            begin
                p_next[c][t] = $signed(a[TERM_A[c][t]]) * $signed(b[TERM_B[c][t]]);
            end
        end
    end

    // stage 2: signed sum of four products per component
    always_comb
    begin
        sum_t acc;
        sum_t term;
        for (int c = 0; c < 4; c++)
        begin
            acc = '0;
            for (int t = 0; t < 4; t++)
            begin
                term = SUM_BITS'(p_reg[c][t]);
                if (TERM_NEG[c][t])
                begin
                    acc = acc - term;
                end
                else
                begin
                    acc = acc + term;
                end
            end
            s_next[c] = acc;
        end
    end

    // stage 3: round half up, then clip to one word
    always_comb
    begin
        sum_t q;
        for (int c = 0; c < 4; c++)
        begin
            q = (s_reg[c] + ROUND_HALF) >>> FRAC_BITS;
            if (q > SUM_MAX)
            begin
                r_next[c]   = SUM_MAX[WORD_BITS-1:0];
                sat_next[c] = 1'b1;
            end
            else if (q < SUM_MIN)
            begin
                r_next[c]   = SUM_MIN[WORD_BITS-1:0];
                sat_next[c] = 1'b1;
            end
            else
            begin
                r_next[c]   = q[WORD_BITS-1:0];
                sat_next[c] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            p_reg     <= p_next;
            side1_reg <= in_side;
        end
        if (rdy[1])
        begin
            s_reg     <= s_next;
            side2_reg <= side1_reg;
        end
        if (rdy[2])
        begin
            r_reg     <= r_next;
            sat_reg   <= sat_next;
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign r         = r_reg;
    assign sat       = sat_reg;
    assign out_side  = side3_reg;

endmodule

[src/quaternion_product_and_rotate.sv]
// top level: quaternion product and vector rotation, two chained multiply units
// path: an accepted job beat goes through both multiply units and then the output register to its result beat
// throughput: one beat per cycle unless result.ready holds it; every stage has its own valid bit and loads
//   when empty or draining, so a held result does not stop upstream stages filling
// the product command passes through the second multiply unit unchanged
// reset: rst_n clears all valid bits asynchronously; data registers are not reset
module quaternion_product_and_rotate
    import qpr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    qpr_in_if.sink        job,
    qpr_out_if.source     result
);

    quat_op_t u1_a;
    quat_op_t u1_b;
    side_t    u1_side_in;
    logic     u1_out_valid;
    logic     u1_out_ready;
    quat_t    u1_r;
    logic [3:0] u1_sat;
    side_t    u1_side_out;

    quat_op_t u2_a;
    quat_op_t u2_b;
    side_t    u2_side_in;
    logic     u2_out_valid;
    logic     u2_out_ready;
    quat_t    u2_r;
    logic [3:0] u2_sat;
    side_t    u2_side_out;

    logic  out_valid_reg;
    logic  out_valid_next;
    quat_t out_r_reg;
    quat_t out_r_next;
    logic  out_sat_reg;
    logic  out_sat_next;
    logic  out_cmd_reg;

    // first pass: a * b, with b_w dropped for a rotate
    assign u1_a[CX] = OP_BITS'($signed(job.a_x));
    assign u1_a[CY] = OP_BITS'($signed(job.a_y));
    assign u1_a[CZ] = OP_BITS'($signed(job.a_z));
    assign u1_a[CW] = OP_BITS'($signed(job.a_w));
    assign u1_b[CX] = OP_BITS'($signed(job.b_x));
    assign u1_b[CY] = OP_BITS'($signed(job.b_y));
    assign u1_b[CZ] = OP_BITS'($signed(job.b_z));
    assign u1_b[CW] = (job.command == CMD_ROTATE) ? '0 : OP_BITS'($signed(job.b_w));

    assign u1_side_in.cmd   = job.command;
    assign u1_side_in.a     = {job.a_w, job.a_z, job.a_y, job.a_x};
    assign u1_side_in.prod  = '0;
    assign u1_side_in.sat   = '0;

    qpr_qmul u_mul1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (job.valid),
        .in_ready  (job.ready),
        .a         (u1_a),
        .b         (u1_b),
        .in_side   (u1_side_in),
        .out_valid (u1_out_valid),
        .out_ready (u1_out_ready),
        .r         (u1_r),
        .sat       (u1_sat),
        .out_side  (u1_side_out)
    );

    // second pass: t * conj(a); conj is one bit wider so negating -2.0 is exact
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            u2_a[c] = OP_BITS'($signed(u1_r[c]));
            if (c == CW)
            begin
                u2_b[c] = OP_BITS'($signed(u1_side_out.a[c]));
            end
            else
            begin
                u2_b[c] = -OP_BITS'($signed(u1_side_out.a[c]));
            end
        end
    end

    assign u2_side_in.cmd  = u1_side_out.cmd;
    assign u2_side_in.a    = u1_side_out.a;
    assign u2_side_in.prod = u1_r;
    assign u2_side_in.sat  = u1_sat;

    qpr_qmul u_mul2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u1_out_valid),
        .in_ready  (u1_out_ready),
        .a         (u2_a),
        .b         (u2_b),
        .in_side   (u2_side_in),
        .out_valid (u2_out_valid),
        .out_ready (u2_out_ready),
        .r         (u2_r),
        .sat       (u2_sat),
        .out_side  (u2_side_out)
    );

    assign u2_out_ready = !out_valid_reg || result.ready;

    always_comb
    begin
        if (u2_side_out.cmd == CMD_ROTATE)
        begin
            out_r_next     = u2_r;
            out_r_next[CW] = '0;
            out_sat_next   = (|u2_side_out.sat) || u2_sat[CX] || u2_sat[CY] || u2_sat[CZ];
        end
        else
        begin
            out_r_next   = u2_side_out.prod;
            out_sat_next = |u2_side_out.sat;
        end
        out_valid_next = out_valid_reg;
        if (u2_out_ready)
        begin
            out_valid_next = u2_out_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (u2_out_ready)
        begin
            out_r_reg   <= out_r_next;
            out_sat_reg <= out_sat_next;
            out_cmd_reg <= u2_side_out.cmd;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.r_x       = out_r_reg[CX];
    assign result.r_y       = out_r_reg[CY];
    assign result.r_z       = out_r_reg[CZ];
    assign result.r_w       = out_r_reg[CW];
    assign result.saturated = out_sat_reg;

    // with the output stage free, every stage behind it can take a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> job.ready)
        else $error("job channel stalled while output stage is empty");

    // a rotate never returns a scalar part
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (out_cmd_reg == CMD_ROTATE) |-> (result.r_w == '0))
        else $error("rotate result carries nonzero w");

    // a product's saturation flag arrives with its result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        u2_out_valid && u2_out_ready && (u2_side_out.cmd == CMD_PRODUCT)
        |=> result.valid && (result.saturated == $past(|u2_side_out.sat)))
        else $error("product saturation flag lost in output stage");

endmodule
